### rtl/kmpq_pkg.sv
// Package with shared constants and the operation type of the keyed priority queue.
package kmpq_pkg;

  localparam int unsigned QueueDepthDef = 1024;
  localparam int unsigned MapSlotsDef   = 2048;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned ValueBitsDef  = 32;

  localparam int unsigned OutBits = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

endpackage

### rtl/kmpq_if.sv
// Valid/ready channel interface carrying an operation or a result.
interface kmpq_req_if #(
  parameter int unsigned KeyBits   = 32,
  parameter int unsigned ValueBits = 32
);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [KeyBits-1:0]   item_key;
  logic [ValueBits-1:0] item_value;

  modport source (output valid, opcode, item_key, item_value, input ready);
  modport sink   (input valid, opcode, item_key, item_value, output ready);
endinterface

interface kmpq_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] out_key;
  logic [31:0] out_value;

  modport source (output valid, success, out_key, out_value, input ready);
  modport sink   (input valid, success, out_key, out_value, output ready);
endinterface

### rtl/keyed_max_priority_queue_top.sv
// Top level of the keyed maximum priority queue with a linear-probing key map.
//
//   Channel  Dir  Contents
//   req      in   opcode, item_key, item_value
//   rsp      out  success, out_key, out_value
//
// One request at a time runs through a small sequencer. Heap and map reads return
// registered data, and MAP_SLOTS must be a power of two.
// An update walks the map probe chain. An insert walks it, then climbs the heap. A
// dequeue scans map slots while closing the gap, then descends the heap.
// After reset a clearing pass zeroes the map valid bits; no request is taken
// meanwhile. A request is taken only the cycle after the previous response left.
module keyed_max_priority_queue_top
  import kmpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned MAP_SLOTS   = MapSlotsDef,
  parameter int unsigned KEY_BITS    = KeyBitsDef,
  parameter int unsigned VALUE_BITS  = ValueBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmpq_req_if.sink    req,
  kmpq_rsp_if.source  rsp
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SW = $clog2(MAP_SLOTS);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAP = (QUEUE_DEPTH < MAP_SLOTS) ? QUEUE_DEPTH : MAP_SLOTS;
  localparam int unsigned KW  = (KEY_BITS < OutBits) ? KEY_BITS : OutBits;
  localparam int unsigned VW  = (VALUE_BITS < OutBits) ? VALUE_BITS : OutBits;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [PW-1:0]         pos_t;
  typedef logic [SW-1:0]         slot_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_FIND_RD, S_FIND_CHK,
    S_UP_RD, S_UP_CHK,
    S_DQ_RD, S_DQ_ROOT,
    S_RM_RD, S_RM_CHK, S_RM_END,
    S_DQ_LAST,
    S_DN_RDL, S_DN_RDR, S_DN_CMP,
    S_PLACE, S_RESP
  } state_e;

  // Memories. Each heap entry also remembers the map slot that holds its key.
  key_t  heap_key_mem  [QUEUE_DEPTH];
  val_t  heap_val_mem  [QUEUE_DEPTH];
  slot_t heap_slot_mem [QUEUE_DEPTH];
  key_t  map_key_mem   [MAP_SLOTS];
  pos_t  map_pos_mem   [MAP_SLOTS];
  logic  map_vld_mem   [MAP_SLOTS];

  state_e        state_q;
  slot_t         clr_q;
  logic [CW-1:0] count_q;
  key_t          key_q, lk_q;
  val_t          val_q, lv_q;
  slot_t         slot_q, ls_q;
  pos_t          i_q;
  slot_t         s_q, gap_q;
  logic [SW:0]   n_q;

  // Registered read data.
  key_t  hk_rd_q;
  val_t  hv_rd_q;
  slot_t hs_rd_q;
  key_t  mk_rd_q;
  pos_t  mp_rd_q;
  logic  mv_rd_q;

  logic        rsp_valid_q, rsp_succ_q;
  logic [31:0] rsp_key_q, rsp_val_q;

  // Heap port request.
  logic  hrd, hkwr, hswr;
  pos_t  hrd_a, hwr_a;
  key_t  hwr_k;
  val_t  hwr_v;
  slot_t hwr_s;
  // Map port request.
  logic  mrd, mwr, mvwr, mvdat;
  slot_t mwr_a, mvwr_a;
  key_t  mwr_k;
  pos_t  mwr_p;

  function automatic slot_t home(key_t k);
    return slot_t'(k);
  endfunction

  assign req.ready     = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid     = rsp_valid_q;
  assign rsp.success   = rsp_succ_q;
  assign rsp.out_key   = rsp_key_q;
  assign rsp.out_value = rsp_val_q;

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (hkwr) begin
      heap_key_mem[hwr_a] <= hwr_k;
      heap_val_mem[hwr_a] <= hwr_v;
    end
    if (hswr) heap_slot_mem[hwr_a] <= hwr_s;
    if (hrd) begin
      hk_rd_q <= heap_key_mem[hrd_a];
      hv_rd_q <= heap_val_mem[hrd_a];
      hs_rd_q <= heap_slot_mem[hrd_a];
    end
    if (mwr) begin
      map_key_mem[mwr_a] <= mwr_k;
      map_pos_mem[mwr_a] <= mwr_p;
    end
    if (mvwr) map_vld_mem[mvwr_a] <= mvdat;
    if (mrd) begin
      mk_rd_q <= map_key_mem[s_q];
      mp_rd_q <= map_pos_mem[s_q];
      mv_rd_q <= map_vld_mem[s_q];
    end
  end

  // Probe and distance helpers for lookup and backward-shift removal.
  logic find_hit, probe_last;
  assign find_hit   = mv_rd_q && (mk_rd_q == key_q);
  assign probe_last = (n_q == (SW+1)'(MAP_SLOTS - 1));

  slot_t dh, dg;
  assign dh = s_q - home(mk_rd_q);
  assign dg = s_q - gap_q;

  // Heap neighbours of the hole and the child choice when sifting down.
  pos_t parent;
  assign parent = pos_t'((i_q - pos_t'(1)) >> 1);
  logic [PW:0] lchild, rchild, cnt_ext;
  assign lchild  = {i_q, 1'b1};
  assign rchild  = {i_q, 1'b0} + (PW+1)'(2);
  assign cnt_ext = (PW+1)'(count_q);

  logic take_l, take_r;
  assign take_l = lk_q > key_q;
  assign take_r = (rchild < cnt_ext) && (hk_rd_q > (take_l ? lk_q : key_q));

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      count_q     <= '0;
      key_q       <= '0;
      val_q       <= '0;
      slot_q      <= '0;
      lk_q        <= '0;
      lv_q        <= '0;
      ls_q        <= '0;
      i_q         <= '0;
      s_q         <= '0;
      gap_q       <= '0;
      n_q         <= '0;
      rsp_valid_q <= 1'b0;
      rsp_succ_q  <= 1'b0;
      rsp_key_q   <= '0;
      rsp_val_q   <= '0;
    end else begin
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + slot_t'(1);
          if (clr_q == slot_t'(MAP_SLOTS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            key_q      <= key_t'(req.item_key);
            val_q      <= val_t'(req.item_value);
            rsp_succ_q <= 1'b0;
            rsp_key_q  <= '0;
            rsp_val_q  <= '0;
            if (req.opcode == OP_ENQ) begin
              s_q     <= home(key_t'(req.item_key));
              n_q     <= '0;
              state_q <= S_FIND_RD;
            end else if (count_q == '0) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_DQ_RD;
            end
          end
        end
        // Lookup of the request key along its probe chain.
        S_FIND_RD: state_q <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (find_hit) begin
            rsp_succ_q <= 1'b1;
            rsp_key_q  <= 32'(key_q[KW-1:0]);
            rsp_val_q  <= 32'(val_q[VW-1:0]);
            state_q    <= S_RESP;
          end else if (!mv_rd_q || probe_last) begin
            if (count_q >= CW'(CAP)) begin
              state_q <= S_RESP;
            end else begin
              // The free slot that ended the probe takes the new key.
              slot_q     <= s_q;
              i_q        <= pos_t'(count_q);
              count_q    <= count_q + CW'(1);
              rsp_succ_q <= 1'b1;
              rsp_key_q  <= 32'(key_q[KW-1:0]);
              rsp_val_q  <= 32'(val_q[VW-1:0]);
              state_q    <= S_UP_RD;
            end
          end else begin
            s_q     <= s_q + slot_t'(1);
            n_q     <= n_q + (SW+1)'(1);
            state_q <= S_FIND_RD;
          end
        end
        // Sift up: smaller parents move down into the hole.
        S_UP_RD: begin
          if (i_q == '0) state_q <= S_PLACE;
          else state_q <= S_UP_CHK;
        end
        S_UP_CHK: begin
          if (hk_rd_q >= key_q) begin
            state_q <= S_PLACE;
          end else begin
            i_q     <= parent;
            state_q <= S_UP_RD;
          end
        end
        // Dequeue: report the root and remove its key from the map.
        S_DQ_RD: state_q <= S_DQ_ROOT;
        S_DQ_ROOT: begin
          rsp_succ_q <= 1'b1;
          rsp_key_q  <= 32'(hk_rd_q[KW-1:0]);
          rsp_val_q  <= 32'(hv_rd_q[VW-1:0]);
          gap_q      <= hs_rd_q;
          s_q        <= hs_rd_q + slot_t'(1);
          n_q        <= '0;
          count_q    <= count_q - CW'(1);
          state_q    <= S_RM_RD;
        end
        S_RM_RD: state_q <= S_RM_CHK;
        S_RM_CHK: begin
          if (!mv_rd_q) begin
            state_q <= S_RM_END;
          end else begin
            if (dh >= dg) gap_q <= s_q;
            if (probe_last) begin
              state_q <= S_RM_END;
            end else begin
              s_q     <= s_q + slot_t'(1);
              n_q     <= n_q + (SW+1)'(1);
              state_q <= S_RM_RD;
            end
          end
        end
        S_RM_END: begin
          if (count_q == '0) state_q <= S_RESP;
          else state_q <= S_DQ_LAST;
        end
        // The last entry is carried from the root downwards.
        S_DQ_LAST: begin
          key_q   <= hk_rd_q;
          val_q   <= hv_rd_q;
          slot_q  <= hs_rd_q;
          i_q     <= '0;
          state_q <= S_DN_RDL;
        end
        S_DN_RDL: begin
          if (lchild >= cnt_ext) state_q <= S_PLACE;
          else state_q <= S_DN_RDR;
        end
        S_DN_RDR: begin
          lk_q    <= hk_rd_q;
          lv_q    <= hv_rd_q;
          ls_q    <= hs_rd_q;
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (take_r) begin
            i_q     <= pos_t'(rchild);
            state_q <= S_DN_RDL;
          end else if (take_l) begin
            i_q     <= pos_t'(lchild);
            state_q <= S_DN_RDL;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: state_q <= S_RESP;
        S_RESP: begin
          rsp_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Memory port control.
  always_comb begin
    hrd    = 1'b0;
    hrd_a  = '0;
    hkwr   = 1'b0;
    hswr   = 1'b0;
    hwr_a  = i_q;
    hwr_k  = key_q;
    hwr_v  = val_q;
    hwr_s  = slot_q;
    mrd    = 1'b0;
    mwr    = 1'b0;
    mwr_a  = slot_q;
    mwr_k  = key_q;
    mwr_p  = i_q;
    mvwr   = 1'b0;
    mvwr_a = gap_q;
    mvdat  = 1'b0;
    unique case (state_q)
      S_CLR: begin
        mvwr   = 1'b1;
        mvwr_a = clr_q;
      end
      S_FIND_RD, S_RM_RD: mrd = 1'b1;
      S_FIND_CHK: begin
        // A present key keeps its place and takes the new value.
        if (find_hit) begin
          hkwr  = 1'b1;
          hwr_a = mp_rd_q;
        end
      end
      S_UP_RD: begin
        if (i_q != '0) begin
          hrd   = 1'b1;
          hrd_a = parent;
        end
      end
      S_UP_CHK: begin
        if (!(hk_rd_q >= key_q)) begin
          hkwr  = 1'b1;
          hswr  = 1'b1;
          hwr_k = hk_rd_q;
          hwr_v = hv_rd_q;
          hwr_s = hs_rd_q;
          mwr   = 1'b1;
          mwr_a = hs_rd_q;
          mwr_k = hk_rd_q;
        end
      end
      S_DQ_RD: hrd = 1'b1;
      S_RM_CHK: begin
        // Shift a displaced entry back into the gap and fix its heap back-pointer.
        if (mv_rd_q && dh >= dg) begin
          mwr   = 1'b1;
          mwr_a = gap_q;
          mwr_k = mk_rd_q;
          mwr_p = mp_rd_q;
          hswr  = 1'b1;
          hwr_a = mp_rd_q;
          hwr_s = gap_q;
        end
      end
      S_RM_END: begin
        mvwr = 1'b1;
        if (count_q != '0) begin
          hrd   = 1'b1;
          hrd_a = pos_t'(count_q);
        end
      end
      S_DN_RDL: begin
        if (lchild < cnt_ext) begin
          hrd   = 1'b1;
          hrd_a = pos_t'(lchild);
        end
      end
      S_DN_RDR: begin
        if (rchild < cnt_ext) begin
          hrd   = 1'b1;
          hrd_a = pos_t'(rchild);
        end
      end
      S_DN_CMP: begin
        if (take_r) begin
          hkwr  = 1'b1;
          hswr  = 1'b1;
          hwr_k = hk_rd_q;
          hwr_v = hv_rd_q;
          hwr_s = hs_rd_q;
          mwr   = 1'b1;
          mwr_a = hs_rd_q;
          mwr_k = hk_rd_q;
        end else if (take_l) begin
          hkwr  = 1'b1;
          hswr  = 1'b1;
          hwr_k = lk_q;
          hwr_v = lv_q;
          hwr_s = ls_q;
          mwr   = 1'b1;
          mwr_a = ls_q;
          mwr_k = lk_q;
        end
      end
      S_PLACE: begin
        hkwr   = 1'b1;
        hswr   = 1'b1;
        mwr    = 1'b1;
        mvwr   = 1'b1;
        mvwr_a = slot_q;
        mvdat  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
